>>> rtl/core/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared constants and request codes for the knob pickup tracker.
// ----------------------------------------------------------------------------
package kpt_pkg;

  // default knob count and legal range
  localparam int unsigned NumKnobsDef = 6;
  localparam int unsigned NumKnobsMax = 8;

  // field widths fixed by the interface
  localparam int unsigned ReqW     = 3;
  localparam int unsigned AdcW     = 10;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ValW     = 8;
  localparam int unsigned MaskW    = 6;
  localparam int unsigned AdcShift = AdcW - ValW;

  // reset value of the tolerance register
  localparam logic [ValW-1:0] MoveTolRst = ValW'(1);

  // request codes
  localparam logic [ReqW-1:0] ReqSample     = 3'd0;
  localparam logic [ReqW-1:0] ReqFreezeVal  = 3'd1;
  localparam logic [ReqW-1:0] ReqFreezeKeep = 3'd2;
  localparam logic [ReqW-1:0] ReqFreezeAll  = 3'd3;
  localparam logic [ReqW-1:0] ReqUnfreeze   = 3'd4;

  // true when v lies between a and b, inclusive, in either order
  function automatic logic lies_between(logic [ValW-1:0] v, logic [ValW-1:0] a,
                                        logic [ValW-1:0] b);
    return ((v <= a) && (v >= b)) || ((v >= a) && (v <= b));
  endfunction

endpackage

>>> rtl/core/knob_pickup_tracker.sv
// ----------------------------------------------------------------------------
// knob_pickup_tracker
// Round-robin knob scanner with soft takeover (pickup) tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : req_type/adc_sample/knob_index/pickup_value with valid/ready.
//                 A sample request stores adc_sample >> 2 as the reading of the
//                 channel under the scan counter and advances the counter.
//                 Other requests freeze or unfreeze knobs or load a pickup value.
//   out channel : one result item per request: channel, its reading and the
//                 moved and frozen masks after the request.
//   cfg channel : writes move_tolerance; always ready, write only while idle.
// Timing:
//   an item is processed while it sits in the input register and lands in
//   the output register when it advances: out_valid_o rises once the item
//   has passed the input register and the output register. One item per
//   cycle is sustained while out_ready_i stays high, since the per-knob
//   state is read and updated by the processing stage alone.
// Reset:
//   scan counter, readings and pickup values clear to zero, all knobs frozen,
//   no knob moved, tolerance 1. No clearing pass.
// Stall:
//   while out_ready_i is low the result holds; the input register still takes
//   one more item, after which in_ready_o drops until the output drains.
// ----------------------------------------------------------------------------
module knob_pickup_tracker #(
  parameter int unsigned NUM_KNOBS = kpt_pkg::NumKnobsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kpt_pkg::ValW-1:0]   cfg_data_i,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kpt_pkg::ReqW-1:0]   req_type_i,
  input  logic [kpt_pkg::AdcW-1:0]   adc_sample_i,
  input  logic [kpt_pkg::IdxW-1:0]   knob_index_i,
  input  logic [kpt_pkg::ValW-1:0]   pickup_value_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kpt_pkg::IdxW-1:0]   sampled_channel_o,
  output logic [kpt_pkg::ValW-1:0]   knob_reading_o,
  output logic [kpt_pkg::MaskW-1:0]  moved_mask_o,
  output logic [kpt_pkg::MaskW-1:0]  frozen_mask_o
);

  localparam int unsigned CntW = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
  localparam logic [CntW-1:0] LastCh = CntW'(NUM_KNOBS - 1);
  localparam int unsigned MaskUsed =
      (NUM_KNOBS < kpt_pkg::MaskW) ? NUM_KNOBS : kpt_pkg::MaskW;

  // tolerance register
  logic [kpt_pkg::ValW-1:0] move_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_tol_q <= kpt_pkg::MoveTolRst;
    end else if (cfg_valid_i) begin
      move_tol_q <= cfg_data_i;
    end
  end

  // handshake control
  logic in_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic s1_adv;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  // input register
  logic [kpt_pkg::ReqW-1:0] req_q;
  logic [kpt_pkg::AdcW-1:0] adc_q;
  logic [kpt_pkg::IdxW-1:0] idx_q;
  logic [kpt_pkg::ValW-1:0] pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      adc_q <= adc_sample_i;
      idx_q <= knob_index_i;
      pv_q  <= pickup_value_i;
    end
  end

  // per-knob state
  logic [CntW-1:0]          ch_q, ch_d;
  logic [kpt_pkg::ValW-1:0] cur_q  [NUM_KNOBS];
  logic [kpt_pkg::ValW-1:0] pick_q [NUM_KNOBS];
  logic [NUM_KNOBS-1:0]     frozen_q, frozen_d;
  logic [NUM_KNOBS-1:0]     moved_q, moved_d;

  // processing logic
  logic [kpt_pkg::ValW-1:0] now_val;
  logic [kpt_pkg::ValW-1:0] old_val;
  logic [kpt_pkg::ValW-1:0] diff;
  logic                     is_moved;
  logic                     in_window;
  logic                     idx_ok;
  logic [CntW-1:0]          idx_ch;
  logic [NUM_KNOBS-1:0]     ch_bit;
  logic [NUM_KNOBS-1:0]     idx_bit;
  logic                     is_sample;
  logic                     load_pick;
  logic [kpt_pkg::ValW-1:0] reading_d;

  assign now_val   = adc_q[kpt_pkg::AdcW-1:kpt_pkg::AdcShift];
  assign old_val   = cur_q[ch_q];
  assign diff      = (old_val > now_val) ? (old_val - now_val) : (now_val - old_val);
  assign is_moved  = diff > move_tol_q;
  assign in_window = kpt_pkg::lies_between(pick_q[ch_q], old_val, now_val);
  assign idx_ok    = 32'(idx_q) < NUM_KNOBS;
  assign idx_ch    = CntW'(idx_q);
  assign ch_bit    = NUM_KNOBS'(1) << ch_q;
  assign idx_bit   = NUM_KNOBS'(1) << idx_q;
  assign is_sample = (req_q == kpt_pkg::ReqSample);
  assign load_pick = (req_q == kpt_pkg::ReqFreezeVal) && idx_ok;
  assign reading_d = is_sample ? now_val : old_val;

  always_comb begin
    ch_d     = ch_q;
    frozen_d = frozen_q;
    moved_d  = moved_q;
    case (req_q)
      kpt_pkg::ReqSample: begin
        if (is_moved) begin
          moved_d  = moved_q | ch_bit;
          frozen_d = frozen_q & ~ch_bit;
        end else begin
          moved_d  = moved_q & ~ch_bit;
        end
        if (in_window) begin
          frozen_d = frozen_d & ~ch_bit;
        end
        ch_d = (ch_q == LastCh) ? '0 : ch_q + CntW'(1);
      end
      kpt_pkg::ReqFreezeVal, kpt_pkg::ReqFreezeKeep: begin
        if (idx_ok) begin
          frozen_d = frozen_q | idx_bit;
        end
      end
      kpt_pkg::ReqFreezeAll: begin
        frozen_d = '1;
      end
      kpt_pkg::ReqUnfreeze: begin
        if (idx_ok) begin
          frozen_d = frozen_q & ~idx_bit;
        end
      end
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q     <= '0;
      frozen_q <= '1;
      moved_q  <= '0;
      for (int i = 0; i < NUM_KNOBS; i++) begin
        cur_q[i]  <= '0;
        pick_q[i] <= '0;
      end
    end else if (s1_adv) begin
      ch_q     <= ch_d;
      frozen_q <= frozen_d;
      moved_q  <= moved_d;
      if (is_sample) begin
        cur_q[ch_q] <= now_val;
      end
      if (load_pick) begin
        pick_q[idx_ch] <= pv_q;
      end
    end
  end

  // mask fitting to the output width
  logic [kpt_pkg::MaskW-1:0] moved_fit;
  logic [kpt_pkg::MaskW-1:0] frozen_fit;

  always_comb begin
    moved_fit  = '0;
    frozen_fit = '0;
    moved_fit[MaskUsed-1:0]  = moved_d[MaskUsed-1:0];
    frozen_fit[MaskUsed-1:0] = frozen_d[MaskUsed-1:0];
  end

  // output register
  logic [kpt_pkg::IdxW-1:0]  och_q;
  logic [kpt_pkg::ValW-1:0]  ord_q;
  logic [kpt_pkg::MaskW-1:0] omov_q;
  logic [kpt_pkg::MaskW-1:0] ofrz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      och_q  <= kpt_pkg::IdxW'(ch_q);
      ord_q  <= reading_d;
      omov_q <= moved_fit;
      ofrz_q <= frozen_fit;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sampled_channel_o = och_q;
  assign knob_reading_o    = ord_q;
  assign moved_mask_o      = omov_q;
  assign frozen_mask_o     = ofrz_q;

  // checks
  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ch_q) < NUM_KNOBS)
    else $error("scan counter out of range");

  a_freeze_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (req_q == kpt_pkg::ReqFreezeAll) |=> (frozen_q == '1))
    else $error("freeze all left a knob unfrozen");

  a_move_unfreeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && is_sample && is_moved |=> ((moved_q & ~frozen_q & $past(ch_bit))
                                         == $past(ch_bit)))
    else $error("moved knob not flagged or still frozen");

  a_counter_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && is_sample) |=> $stable(ch_q))
    else $error("scan counter moved without a sample");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("processed item produced no result");

endmodule

>>> test/knob_pickup_tracker_test.sv
// ----------------------------------------------------------------------------
// knob_pickup_tracker_test
// Self-checking bench for the knob pickup tracker: a queue-fed driver offers
// requests, a clocked monitor predicts each accepted request's result with an
// in-bench knob model and compares it field by field against the result port.
// Runs a directed set, then random phases at several tolerances and with
// sender idling, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module knob_pickup_tracker_test;
  import kpt_pkg::*;

  localparam int unsigned NumKnobs = NumKnobsDef;
  localparam logic [NumKnobsMax-1:0] KnobMask = NumKnobsMax'((1 << NumKnobs) - 1);
  localparam logic [ReqW-1:0] ReqLastKnown = ReqUnfreeze;
  localparam logic [ReqW-1:0] ReqTop = '1;

  typedef struct packed {
    logic [ReqW-1:0] kind;
    logic [AdcW-1:0] adc;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] pv;
  } knob_req_t;

  typedef struct packed {
    logic [IdxW-1:0]  chan;
    logic [ValW-1:0]  reading;
    logic [MaskW-1:0] moved;
    logic [MaskW-1:0] frozen;
  } knob_report_t;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ValW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ReqW-1:0]   req_type_i = '0;
  logic [AdcW-1:0]   adc_sample_i = '0;
  logic [IdxW-1:0]   knob_index_i = '0;
  logic [ValW-1:0]   pickup_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IdxW-1:0]   sampled_channel_o;
  logic [ValW-1:0]   knob_reading_o;
  logic [MaskW-1:0]  moved_mask_o;
  logic [MaskW-1:0]  frozen_mask_o;

  knob_pickup_tracker #(.NUM_KNOBS(NumKnobs)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .req_type_i(req_type_i), .adc_sample_i(adc_sample_i),
    .knob_index_i(knob_index_i), .pickup_value_i(pickup_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sampled_channel_o(sampled_channel_o), .knob_reading_o(knob_reading_o),
    .moved_mask_o(moved_mask_o), .frozen_mask_o(frozen_mask_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted knob state
  logic [ValW-1:0]        move_tol = MoveTolRst;
  logic [IdxW-1:0]        scan_chan = '0;
  logic [ValW-1:0]        cur_rd [NumKnobsMax];
  logic [ValW-1:0]        pickup [NumKnobsMax];
  logic [NumKnobsMax-1:0] frozen = KnobMask;
  logic [NumKnobsMax-1:0] moved = '0;

  // stimulus-side shadow of the scan, used to aim samples near old readings
  int unsigned     gen_chan = 0;
  logic [ValW-1:0] gen_rd [NumKnobsMax];
  int unsigned     gen_tol = MoveTolRst;

  knob_req_t    req_backlog[$];
  knob_report_t pending_reports[$];
  int unsigned  reqs_queued = 0;
  int unsigned  reqs_taken = 0;
  logic         req_taken = 1'b0;
  int unsigned  err_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  bit           hold_arm = 1'b0;
  int unsigned  hold_left = 0;

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // one request through the knob model, returns the result it must produce
  function automatic knob_report_t track_knobs(knob_req_t r);
    logic [IdxW-1:0]        ch;
    logic [ValW-1:0]        old_rd;
    logic [ValW-1:0]        new_rd;
    logic [ValW-1:0]        diff;
    logic [NumKnobsMax-1:0] bit_m;
    logic                   idx_ok;
    knob_report_t           rep;
    ch = scan_chan;
    idx_ok = (r.idx < NumKnobs);
    if (r.kind == ReqSample) begin
      if (ch >= NumKnobs) ch = '0;
      bit_m = NumKnobsMax'(1) << ch;
      old_rd = cur_rd[ch];
      new_rd = ValW'(r.adc >> AdcShift);
      cur_rd[ch] = new_rd;
      diff = (old_rd > new_rd) ? old_rd - new_rd : new_rd - old_rd;
      if (diff > move_tol) begin
        moved = moved | bit_m;
        frozen = frozen & ~bit_m;
      end else begin
        moved = moved & ~bit_m;
      end
      // soft takeover: pickup point crossed or touched
      if ((pickup[ch] <= old_rd && pickup[ch] >= new_rd) ||
          (pickup[ch] >= old_rd && pickup[ch] <= new_rd)) begin
        frozen = frozen & ~bit_m;
      end
      scan_chan = (int'(ch) + 1 >= NumKnobs) ? '0 : ch + 1'b1;
    end else begin
      case (r.kind)
        ReqFreezeVal: begin
          if (idx_ok) begin
            pickup[r.idx] = r.pv;
            frozen[r.idx] = 1'b1;
          end
        end
        ReqFreezeKeep: begin
          if (idx_ok) frozen[r.idx] = 1'b1;
        end
        ReqFreezeAll: begin
          frozen = KnobMask;
        end
        ReqUnfreeze: begin
          if (idx_ok) frozen[r.idx] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    rep.chan = ch;
    rep.reading = cur_rd[ch];
    rep.moved = moved[MaskW-1:0];
    rep.frozen = frozen[MaskW-1:0];
    return rep;
  endfunction

  // queue one request and follow the scan on the stimulus side
  function automatic void push_request(logic [ReqW-1:0] kind, logic [AdcW-1:0] adc,
                                       logic [IdxW-1:0] idx, logic [ValW-1:0] pv);
    knob_req_t r;
    r = '{kind: kind, adc: adc, idx: idx, pv: pv};
    req_backlog.push_back(r);
    reqs_queued++;
    if (kind == ReqSample) begin
      gen_rd[gen_chan] = ValW'(adc >> AdcShift);
      gen_chan = (gen_chan + 1 >= NumKnobs) ? 0 : gen_chan + 1;
    end
  endfunction

  // value close to base, at distances around the tolerance
  function automatic logic [ValW-1:0] near_value(logic [ValW-1:0] base, int unsigned span);
    int v;
    v = int'(base) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(span));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ValW'(v);
  endfunction

  // random request, weighted toward samples near the previous reading
  function automatic void push_random_request();
    int unsigned     roll;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] rd;
    logic [AdcW-1:0] adc;
    logic [ValW-1:0] pv;
    roll = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? IdxW'($urandom_range(NumKnobs, NumKnobsMax - 1))
                                   : IdxW'($urandom_range(NumKnobs - 1));
    adc = AdcW'($urandom);
    pv = ValW'($urandom);
    if (roll < 55) begin
      if ($urandom_range(3) != 0) begin
        rd = near_value(gen_rd[gen_chan], (gen_tol > 250) ? 255 : gen_tol + 3);
        adc = {rd, AdcShift'($urandom)};
      end
      push_request(ReqSample, adc, IdxW'($urandom), pv);
    end else if (roll < 67) begin
      if ($urandom_range(1)) pv = near_value(gen_rd[idx], 4);
      push_request(ReqFreezeVal, adc, idx, pv);
    end else if (roll < 75) begin
      push_request(ReqFreezeKeep, adc, idx, pv);
    end else if (roll < 80) begin
      push_request(ReqFreezeAll, adc, IdxW'($urandom), pv);
    end else if (roll < 93) begin
      push_request(ReqUnfreeze, adc, idx, pv);
    end else begin
      push_request(ReqW'($urandom_range(ReqLastKnown + 1, ReqTop)), adc, IdxW'($urandom), pv);
    end
  endfunction

  // every accepted request answered and checked
  task automatic wait_drained();
    while (reqs_taken != reqs_queued || pending_reports.size() != 0) @(negedge clk_i);
  endtask

  // new tolerance, then a batch of random requests under the given idling, stalls and hold-off
  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall,
                           logic [ValW-1:0] tol, bit long_hold);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= tol;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    gen_tol = tol;
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) push_random_request();
    if (long_hold) hold_arm = 1'b1;
  endtask

  // request driver
  always @(negedge clk_i) begin : drive_requests
    knob_req_t nxt;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.kind;
        adc_sample_i <= nxt.adc;
        knob_index_i <= nxt.idx;
        pickup_value_i <= nxt.pv;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result-side ready, with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_arm) begin
      out_ready_i <= 1'b0;
      hold_arm = 1'b0;
      hold_left = 80;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on acceptance, compare on each delivered result
  always @(posedge clk_i) begin : watch_results
    knob_report_t want;
    req_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) move_tol = cfg_data_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_reports.push_back(track_knobs('{kind: req_type_i, adc: adc_sample_i,
                                              idx: knob_index_i, pv: pickup_value_i}));
      reqs_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, channel %0d",
                                  sampled_channel_o));
      end else begin
        want = pending_reports.pop_front();
        if (sampled_channel_o !== want.chan)
          report_mismatch($sformatf("sampled_channel got %0d want %0d",
                                    sampled_channel_o, want.chan));
        if (knob_reading_o !== want.reading)
          report_mismatch($sformatf("knob_reading got %0d want %0d",
                                    knob_reading_o, want.reading));
        if (moved_mask_o !== want.moved)
          report_mismatch($sformatf("moved_mask got %b want %b", moved_mask_o, want.moved));
        if (frozen_mask_o !== want.frozen)
          report_mismatch($sformatf("frozen_mask got %b want %b",
                                    frozen_mask_o, want.frozen));
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < NumKnobsMax; i++) begin
      cur_rd[i] = '0;
      pickup[i] = '0;
      gen_rd[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset tolerance, full-scale samples, threshold and pickup edges
    push_request(ReqSample, 10'd1023, 3'd0, 8'd0);      // jump to full scale
    push_request(ReqSample, 10'd8, 3'd0, 8'd0);         // one above tolerance
    push_request(ReqSample, 10'd7, 3'd0, 8'd0);         // equal to tolerance
    push_request(ReqFreezeVal, 10'd0, 3'd3, 8'd255);
    push_request(ReqFreezeVal, 10'd1023, 3'd4, 8'd0);
    push_request(ReqSample, 10'd1020, 3'd0, 8'd0);      // lands on pickup exactly
    push_request(ReqFreezeKeep, 10'd0, 3'd0, 8'd0);
    push_request(ReqUnfreeze, 10'd0, 3'd5, 8'd0);
    push_request(ReqFreezeVal, 10'd0, 3'd6, 8'd77);     // index past last knob
    push_request(ReqFreezeKeep, 10'd0, 3'd7, 8'd0);
    push_request(ReqUnfreeze, 10'd0, 3'd7, 8'd0);
    push_request(ReqLastKnown + 3'd1, 10'd1023, 3'd2, 8'd255);  // unknown request
    push_request(ReqTop, 10'd0, 3'd1, 8'd1);
    push_request(ReqFreezeAll, 10'd0, 3'd0, 8'd0);
    push_request(ReqSample, 10'd0, 3'd0, 8'd0);         // no change, pickup at reading
    push_request(ReqSample, 10'd3, 3'd0, 8'd0);         // last knob, scan wraps
    push_request(ReqSample, 10'd1019, 3'd0, 8'd0);      // small step clears moved
    push_request(ReqFreezeVal, 10'd0, 3'd1, 8'd100);
    push_request(ReqSample, 10'd400, 3'd0, 8'd0);       // new reading equals pickup
    push_request(ReqUnfreeze, 10'd0, 3'd0, 8'd0);

    run_phase(200, 0, 0, 8'd0, 1'b1);
    run_phase(150, 47, 0, 8'd255, 1'b0);
    run_phase(200, 0, 47, ValW'($urandom_range(2, 12)), 1'b0);
    run_phase(180, 23, 23, 8'd1, 1'b0);
    run_phase(100, 0, 0, ValW'($urandom_range(0, 255)), 1'b1);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("knob_pickup_tracker_test: done, clean");
    end else begin
      $display("knob_pickup_tracker_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("knob_pickup_tracker_test: done, errors");
    $finish;
  end

endmodule
